// ===== design/adtg_pkg.sv =====
// ----------------------------------------------------------------------------
// adtg_pkg
// Shared types and constants for the detail tier governor.
// ----------------------------------------------------------------------------
package adtg_pkg;

  localparam int NUM_BUCKETS = 101;
  localparam int SPAN        = 2;
  localparam int TAPS        = 2 * SPAN + 1;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int SIDX_W      = IDX_W + 2;
  localparam int TAP_W       = $clog2(TAPS);

  localparam int FT_W    = 18;
  localparam int CNT_W   = 16;
  localparam int RATIO_W = 10;
  localparam int HOLD_W  = 8;
  localparam int SMP_W   = 8;
  localparam int W_W     = 9;

  localparam int W_CENTER  = 256;
  localparam int W_NEAR    = 166;
  localparam int W_FAR     = 90;
  localparam int WSUM_MAX  = W_CENTER + 2 * W_NEAR + (TAPS - 3) * W_FAR;
  localparam int WS_W      = $clog2(WSUM_MAX + 1);
  localparam int ACC_W     = FT_W + WS_W;
  localparam int PROD_W    = 30;

  localparam int ALPHA     = 328;
  localparam int ALPHA_INV = 4096 - ALPHA;
  localparam int FT_MAX    = 256000;
  localparam int SMP_CLAMP = 240;
  localparam int CNT_MAX   = 65535;

  // functions of an input word
  localparam logic [1:0] FUNC_OBSERVE = 2'd0;
  localparam logic [1:0] FUNC_QUERY   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  // detail tiers
  localparam logic [1:0] TIER_NORMAL  = 2'd0;
  localparam logic [1:0] TIER_REDUCED = 2'd1;
  localparam logic [1:0] TIER_ULTRA   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BUDGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCED_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ULTRA_RATIO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPGRADE_HOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES   = 3'd5;

  typedef struct packed {
    logic [FT_W-1:0]  avg;
    logic [CNT_W-1:0] cnt;
  } bkt_t;

  localparam int BKT_W = FT_W + CNT_W;

endpackage

// ===== design/adtg_ram.sv =====
// ----------------------------------------------------------------------------
// adtg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module adtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/adtg_div.sv =====
// ----------------------------------------------------------------------------
// adtg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adtg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [adtg_pkg::ACC_W-1:0] dividend,
  input  logic [adtg_pkg::WS_W-1:0]  divisor,
  output logic                       busy,
  output logic [adtg_pkg::FT_W-1:0]  quotient
);

  localparam int CW = $clog2(adtg_pkg::ACC_W + 1);

  logic [adtg_pkg::ACC_W-1:0] dvd_r, dvd_nxt;
  logic [adtg_pkg::WS_W:0]    rem_r, rem_nxt, rem_sh;
  logic [adtg_pkg::WS_W-1:0]  dsr_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r[adtg_pkg::WS_W-1:0], dvd_r[adtg_pkg::ACC_W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(adtg_pkg::ACC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        dvd_nxt = {dvd_r[adtg_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[adtg_pkg::ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r[adtg_pkg::FT_W-1:0];

endmodule

// ===== design/adaptive_detail_tier_governor.sv =====
// ----------------------------------------------------------------------------
// adaptive_detail_tier_governor
// Learns frame time per load bucket and governs the active detail tier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one word per frame: func,
//   load_percent, frame_time. Result channel (out_valid/out_stall) returns
//   exactly one word per input word. cfg_* writes one register per word;
//   cfg_ready is always high, writes are meant for idle periods only.
//   One item at a time: in_stall is high from acceptance until the result
//   is parked in the output register. A reset-session or zero-budget word
//   goes straight to the hand-off; any other word passes the bucket update
//   (accepted observe words only), a read per neighbour tap (5 taps), the
//   rounding divider when a neighbour holds samples, the tier compares and
//   the hand-off. Most of the time per word is spent in the divider and at
//   the single bucket RAM port.
//   The next word can be taken while the result sits in the output register,
//   even if the receiver still stalls it; a stalled result holds.
//   Reset clears the control state, the per-bucket valid bits (so every
//   count reads zero), the tier and the vote counters, and loads the
//   register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module adaptive_detail_tier_governor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_func,
  input  logic [6:0]                           in_load_percent,
  input  logic [adtg_pkg::FT_W-1:0]            in_frame_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic                                 out_history_found,
  output logic [adtg_pkg::FT_W-1:0]            out_learned_frame_time,
  output logic [adtg_pkg::SMP_W-1:0]           out_neighbour_samples,
  output logic [1:0]                           out_wanted_tier,
  output logic [1:0]                           out_active_tier,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adtg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adtg_pkg::FT_W-1:0]            cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_MUL  = 4'd2;
  localparam logic [3:0] S_UP_ADD  = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_MUL  = 4'd5;
  localparam logic [3:0] S_SC_ADD  = 4'd6;
  localparam logic [3:0] S_DV_GO   = 4'd7;
  localparam logic [3:0] S_DV_WAIT = 4'd8;
  localparam logic [3:0] S_CM1     = 4'd9;
  localparam logic [3:0] S_CM2     = 4'd10;
  localparam logic [3:0] S_CM3     = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  localparam int IW = adtg_pkg::IDX_W;
  localparam int SW = adtg_pkg::SIDX_W;

  // configuration registers
  logic [adtg_pkg::FT_W-1:0]    budget_r;
  logic [adtg_pkg::RATIO_W-1:0] red_ratio_r, ult_ratio_r;
  logic [adtg_pkg::HOLD_W-1:0]  up_hold_r, rec_hold_r;
  logic [adtg_pkg::SMP_W-1:0]   min_smp_r;

  // control / working state
  logic [3:0]                   state_r, state_nxt;
  logic [adtg_pkg::NUM_BUCKETS-1:0] vld_r, vld_nxt;
  logic [1:0]                   tier_r, tier_nxt;
  logic [adtg_pkg::HOLD_W-1:0]  upv_r, upv_nxt, recv_r, recv_nxt;
  logic [IW-1:0]                idx_r, idx_nxt, ra_r;
  logic [adtg_pkg::FT_W-1:0]    ft_r, ft_nxt;
  logic [adtg_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [adtg_pkg::TAP_W-1:0]   tap_r, tap_nxt;
  logic [adtg_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [adtg_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [adtg_pkg::WS_W-1:0]    wsum_r, wsum_nxt;
  logic [adtg_pkg::SMP_W-1:0]   total_r, total_nxt;
  logic [1:0]                   wanted_r, wanted_nxt;
  logic                         acc_flag_r, acc_flag_nxt;
  logic                         ult_hit_r, ult_hit_nxt;

  // output word
  logic                         ov_r;
  logic                         o_acc_r, o_hist_r;
  logic [adtg_pkg::FT_W-1:0]    o_lft_r;
  logic [adtg_pkg::SMP_W-1:0]   o_smp_r;
  logic [1:0]                   o_want_r, o_tier_r;

  // bucket memory
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  adtg_pkg::bkt_t               ram_wdata, ram_rdata;
  logic [adtg_pkg::CNT_W-1:0]   cnt_eff;

  // divider
  logic                         div_start, div_busy;
  logic [adtg_pkg::FT_W-1:0]    div_q;
  logic [adtg_pkg::ACC_W-1:0]   div_dvd;

  // tap address
  logic signed [SW-1:0]         r_s;
  logic                         r_in;
  logic [adtg_pkg::W_W-1:0]     tap_w;
  logic                         tap_last;

  logic                         in_acc, do_upd, out_free;
  logic [IW-1:0]                idx_in;
  logic [30:0]                  upd_sum;
  logic [adtg_pkg::CNT_W:0]     tot_sum;
  logic [25:0]                  lhs;
  logic [1:0]                   want_c;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_free = !ov_r || !out_stall;
  assign cfg_ready = 1'b1;

  // --- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= adtg_pkg::FT_W'(4267);
      red_ratio_r <= adtg_pkg::RATIO_W'(287);
      ult_ratio_r <= adtg_pkg::RATIO_W'(371);
      up_hold_r   <= adtg_pkg::HOLD_W'(18);
      rec_hold_r  <= adtg_pkg::HOLD_W'(120);
      min_smp_r   <= adtg_pkg::SMP_W'(20);
    end else if (cfg_valid) begin
      case (cfg_index)
        adtg_pkg::REG_FRAME_BUDGET:  budget_r    <= cfg_data;
        adtg_pkg::REG_REDUCED_RATIO: red_ratio_r <= cfg_data[adtg_pkg::RATIO_W-1:0];
        adtg_pkg::REG_ULTRA_RATIO:   ult_ratio_r <= cfg_data[adtg_pkg::RATIO_W-1:0];
        adtg_pkg::REG_UPGRADE_HOLD:  up_hold_r   <= cfg_data[adtg_pkg::HOLD_W-1:0];
        adtg_pkg::REG_RECOVERY_HOLD: rec_hold_r  <= cfg_data[adtg_pkg::HOLD_W-1:0];
        adtg_pkg::REG_MIN_SAMPLES:   min_smp_r   <= cfg_data[adtg_pkg::SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // --- bucket RAM: {average, count}; a bucket without its valid bit counts zero
  adtg_ram #(
    .WIDTH (adtg_pkg::BKT_W),
    .DEPTH (adtg_pkg::NUM_BUCKETS)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_eff = vld_r[ra_r] ? ram_rdata.cnt : '0;

  adtg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (wsum_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // rounding: (acc + wsum/2) / wsum
  assign div_dvd = acc_r + adtg_pkg::ACC_W'(wsum_r >> 1);

  // neighbour address for the current tap
  assign r_s  = signed'({2'b00, idx_r}) + signed'(SW'(tap_r)) - signed'(SW'(adtg_pkg::SPAN));
  assign r_in = (r_s >= 0) && (r_s < signed'(SW'(adtg_pkg::NUM_BUCKETS)));
  assign tap_last = tap_r == adtg_pkg::TAP_W'(adtg_pkg::TAPS - 1);

  always_comb begin
    if (tap_r == adtg_pkg::TAP_W'(adtg_pkg::SPAN)) begin
      tap_w = adtg_pkg::W_W'(adtg_pkg::W_CENTER);
    end else if (tap_r == adtg_pkg::TAP_W'(adtg_pkg::SPAN - 1) ||
                 tap_r == adtg_pkg::TAP_W'(adtg_pkg::SPAN + 1)) begin
      tap_w = adtg_pkg::W_W'(adtg_pkg::W_NEAR);
    end else begin
      tap_w = adtg_pkg::W_W'(adtg_pkg::W_FAR);
    end
  end

  assign ram_raddr = (state_r == S_UP_RD) ? idx_r : r_s[IW-1:0];

  // load clamp to the last bucket
  assign idx_in = (int'(in_load_percent) > adtg_pkg::NUM_BUCKETS - 1) ?
                  IW'(adtg_pkg::NUM_BUCKETS - 1) : IW'(in_load_percent);
  assign do_upd = (in_func == adtg_pkg::FUNC_OBSERVE) && (in_frame_time != '0) &&
                  (int'(in_frame_time) <= adtg_pkg::FT_MAX) && (budget_r != '0);

  // EMA: avg*(4096-alpha) is in prod_r, add ft*alpha and round
  assign upd_sum = 31'(prod_r) + 31'(ft_r) * 31'(adtg_pkg::ALPHA) + 31'(2048);
  assign tot_sum = {1'b0, cnt_eff} + (adtg_pkg::CNT_W+1)'(total_r);
  assign lhs     = {div_q, 8'b0};

  always_comb begin
    if (total_r < min_smp_r) begin
      want_c = adtg_pkg::TIER_NORMAL;
    end else if (ult_hit_r) begin
      want_c = adtg_pkg::TIER_ULTRA;
    end else if (adtg_pkg::PROD_W'(lhs) >= prod_r) begin
      want_c = adtg_pkg::TIER_REDUCED;
    end else begin
      want_c = adtg_pkg::TIER_NORMAL;
    end
  end

  // --- sequencer
  always_comb begin
    state_nxt    = state_r;
    vld_nxt      = vld_r;
    tier_nxt     = tier_r;
    upv_nxt      = upv_r;
    recv_nxt     = recv_r;
    idx_nxt      = idx_r;
    ft_nxt       = ft_r;
    cnt_nxt      = cnt_r;
    tap_nxt      = tap_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    wsum_nxt     = wsum_r;
    total_nxt    = total_r;
    wanted_nxt   = wanted_r;
    acc_flag_nxt = acc_flag_r;
    ult_hit_nxt  = ult_hit_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = '0;
    div_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt      = idx_in;
          ft_nxt       = in_frame_time;
          acc_nxt      = '0;
          wsum_nxt     = '0;
          total_nxt    = '0;
          wanted_nxt   = adtg_pkg::TIER_NORMAL;
          tap_nxt      = '0;
          acc_flag_nxt = 1'b0;
          if (in_func == adtg_pkg::FUNC_CLEAR) begin
            vld_nxt   = '0;
            tier_nxt  = adtg_pkg::TIER_NORMAL;
            upv_nxt   = '0;
            recv_nxt  = '0;
            state_nxt = S_FIN;
          end else if (budget_r == '0) begin
            state_nxt = S_FIN;
          end else if (do_upd) begin
            acc_flag_nxt = 1'b1;
            state_nxt    = S_UP_RD;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_UP_RD: state_nxt = S_UP_MUL;
      S_UP_MUL: begin
        if (cnt_eff == '0) begin
          ram_we        = 1'b1;
          ram_wdata.avg = ft_r;
          ram_wdata.cnt = adtg_pkg::CNT_W'(1);
          vld_nxt[idx_r] = 1'b1;
          state_nxt     = S_SC_RD;
        end else begin
          prod_nxt  = adtg_pkg::PROD_W'(ram_rdata.avg) *
                      adtg_pkg::PROD_W'(adtg_pkg::ALPHA_INV);
          cnt_nxt   = cnt_eff;
          state_nxt = S_UP_ADD;
        end
      end
      S_UP_ADD: begin
        ram_we        = 1'b1;
        ram_wdata.avg = upd_sum[29:12];
        ram_wdata.cnt = (int'(cnt_r) == adtg_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
        state_nxt     = S_SC_RD;
      end
      S_SC_RD: begin
        if (r_in) begin
          state_nxt = S_SC_MUL;
        end else begin
          tap_nxt   = tap_r + 1'b1;
          state_nxt = tap_last ? S_DV_GO : S_SC_RD;
        end
      end
      S_SC_MUL: begin
        if (cnt_eff != '0) begin
          prod_nxt  = adtg_pkg::PROD_W'(ram_rdata.avg) * adtg_pkg::PROD_W'(tap_w);
          wsum_nxt  = wsum_r + adtg_pkg::WS_W'(tap_w);
          total_nxt = (int'(tot_sum) > adtg_pkg::SMP_CLAMP) ?
                      adtg_pkg::SMP_W'(adtg_pkg::SMP_CLAMP) : tot_sum[adtg_pkg::SMP_W-1:0];
          state_nxt = S_SC_ADD;
        end else begin
          tap_nxt   = tap_r + 1'b1;
          state_nxt = tap_last ? S_DV_GO : S_SC_RD;
        end
      end
      S_SC_ADD: begin
        acc_nxt   = acc_r + adtg_pkg::ACC_W'(prod_r);
        tap_nxt   = tap_r + 1'b1;
        state_nxt = tap_last ? S_DV_GO : S_SC_RD;
      end
      S_DV_GO: begin
        if (wsum_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DV_WAIT;
        end
      end
      S_DV_WAIT: begin
        if (!div_busy) begin
          state_nxt = S_CM1;
        end
      end
      S_CM1: begin
        prod_nxt  = adtg_pkg::PROD_W'(ult_ratio_r) * adtg_pkg::PROD_W'(budget_r);
        state_nxt = S_CM2;
      end
      S_CM2: begin
        ult_hit_nxt = adtg_pkg::PROD_W'(lhs) >= prod_r;
        prod_nxt    = adtg_pkg::PROD_W'(red_ratio_r) * adtg_pkg::PROD_W'(budget_r);
        state_nxt   = S_CM3;
      end
      S_CM3: begin
        wanted_nxt = want_c;
        if (acc_flag_r) begin
          if (want_c > tier_r) begin
            upv_nxt  = (upv_r == '1) ? upv_r : upv_r + 1'b1;
            recv_nxt = '0;
            if (upv_nxt >= up_hold_r) begin
              tier_nxt = want_c;
              upv_nxt  = '0;
            end
          end else if (want_c < tier_r) begin
            recv_nxt = (recv_r == '1) ? recv_r : recv_r + 1'b1;
            upv_nxt  = '0;
            if (recv_nxt >= rec_hold_r) begin
              tier_nxt = want_c;
              recv_nxt = '0;
            end
          end else begin
            upv_nxt  = '0;
            recv_nxt = '0;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      tier_r     <= adtg_pkg::TIER_NORMAL;
      upv_r      <= '0;
      recv_r     <= '0;
      ov_r       <= 1'b0;
      acc_flag_r <= 1'b0;
      wsum_r     <= '0;
      total_r    <= '0;
      wanted_r   <= adtg_pkg::TIER_NORMAL;
    end else begin
      state_r    <= state_nxt;
      vld_r      <= vld_nxt;
      tier_r     <= tier_nxt;
      upv_r      <= upv_nxt;
      recv_r     <= recv_nxt;
      acc_flag_r <= acc_flag_nxt;
      wsum_r     <= wsum_nxt;
      total_r    <= total_nxt;
      wanted_r   <= wanted_nxt;
      if (state_r == S_FIN && out_free) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
    idx_r   <= idx_nxt;
    ft_r    <= ft_nxt;
    cnt_r   <= cnt_nxt;
    tap_r   <= tap_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    ult_hit_r <= ult_hit_nxt;
    ra_r    <= ram_raddr;
    if (state_r == S_FIN && out_free) begin
      o_acc_r  <= acc_flag_r;
      o_hist_r <= wsum_r != '0;
      o_lft_r  <= (wsum_r != '0) ? div_q : '0;
      o_smp_r  <= total_r;
      o_want_r <= wanted_r;
      o_tier_r <= tier_r;
    end
  end

  assign out_valid              = ov_r;
  assign out_accepted           = o_acc_r;
  assign out_history_found      = o_hist_r;
  assign out_learned_frame_time = o_lft_r;
  assign out_neighbour_samples  = o_smp_r;
  assign out_wanted_tier        = o_want_r;
  assign out_active_tier        = o_tier_r;

  // --- checks
  a_tier_legal: assert property (@(posedge clk) disable iff (!rst_n)
    tier_r != 2'd3) else $error("active tier out of range");

  a_votes_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(upv_r != '0 && recv_r != '0)) else $error("up and down votes both pending");

  a_total_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= adtg_pkg::SMP_CLAMP) else $error("sample total above clamp");

  a_clear_table: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == adtg_pkg::FUNC_CLEAR) |=> vld_r == '0)
    else $error("session clear left valid buckets");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for adaptive_detail_tier_governor. A shadow model of
// the bucket table, the vote counters and the registers predicts every
// result word; words are compared field by field in order. Traffic is mostly
// clustered observe runs that drive the tier up and down, mixed with
// queries, session clears, rejected frame times and full-range noise, under
// several register settings.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    bit                      acc;
    bit                      hist;
    bit [adtg_pkg::FT_W-1:0] learned;
    bit [7:0]                smp;
    bit [1:0]                want;
    bit [1:0]                act;
  } tier_word_t;

  // Shadow of the governor: bucket table, tier and votes, plus registers.
  class governor_tracker;
    bit [adtg_pkg::FT_W-1:0]  avg_tab [adtg_pkg::NUM_BUCKETS];
    bit [adtg_pkg::CNT_W-1:0] cnt_tab [adtg_pkg::NUM_BUCKETS];
    bit [1:0]       tier;
    int unsigned    up_votes, down_votes;
    int unsigned    budget, red_ratio, ult_ratio, up_hold, down_hold, min_smp;
    tier_word_t     expected_words[$];
    int unsigned    words_in, words_out, errors, tier_moves;

    function void clear_session();
      foreach (cnt_tab[i]) begin
        cnt_tab[i] = '0;
        avg_tab[i] = '0;
      end
      tier = adtg_pkg::TIER_NORMAL;
      up_votes = 0;
      down_votes = 0;
    endfunction

    function void load_defaults();
      clear_session();
      budget = 4267; red_ratio = 287; ult_ratio = 371;
      up_hold = 18; down_hold = 120; min_smp = 20;
    endfunction

    function void write_reg(logic [adtg_pkg::CFG_IDX_W-1:0] idx,
                            logic [adtg_pkg::FT_W-1:0] val);
      case (idx)
        adtg_pkg::REG_FRAME_BUDGET:  budget    = 32'(val);
        adtg_pkg::REG_REDUCED_RATIO: red_ratio = 32'(val[adtg_pkg::RATIO_W-1:0]);
        adtg_pkg::REG_ULTRA_RATIO:   ult_ratio = 32'(val[adtg_pkg::RATIO_W-1:0]);
        adtg_pkg::REG_UPGRADE_HOLD:  up_hold   = 32'(val[adtg_pkg::HOLD_W-1:0]);
        adtg_pkg::REG_RECOVERY_HOLD: down_hold = 32'(val[adtg_pkg::HOLD_W-1:0]);
        adtg_pkg::REG_MIN_SAMPLES:   min_smp   = 32'(val[adtg_pkg::SMP_W-1:0]);
        default: ;
      endcase
    endfunction

    // weighted neighbour average and wanted tier around bucket c
    function tier_word_t judge(int c);
      tier_word_t w;
      longint unsigned acc, wsum, total, lhs;
      int r, wt;
      w = '{default: 0};
      acc = 0; wsum = 0; total = 0;
      if (budget == 0) return w;
      for (int d = -adtg_pkg::SPAN; d <= adtg_pkg::SPAN; d++) begin
        r = c + d;
        if (r < 0 || r >= adtg_pkg::NUM_BUCKETS) continue;
        if (cnt_tab[r] == 0) continue;
        wt = (d == 0) ? adtg_pkg::W_CENTER :
             ((d == 1 || d == -1) ? adtg_pkg::W_NEAR : adtg_pkg::W_FAR);
        acc += longint'(avg_tab[r]) * wt;
        wsum += wt;
        total += cnt_tab[r];
      end
      if (wsum == 0) return w;
      w.hist = 1;
      w.learned = adtg_pkg::FT_W'((acc + wsum / 2) / wsum);
      w.smp = 8'((total > adtg_pkg::SMP_CLAMP) ? adtg_pkg::SMP_CLAMP : total);
      if (w.smp >= min_smp) begin
        lhs = longint'(w.learned) << 8;
        if (lhs >= longint'(ult_ratio) * budget) w.want = adtg_pkg::TIER_ULTRA;
        else if (lhs >= longint'(red_ratio) * budget) w.want = adtg_pkg::TIER_REDUCED;
      end
      return w;
    endfunction

    function void cast_vote(bit [1:0] want);
      if (want > tier) begin
        if (up_votes < 255) up_votes++;
        down_votes = 0;
        if (up_votes >= up_hold) begin
          tier = want; up_votes = 0; tier_moves++;
        end
      end else if (want < tier) begin
        if (down_votes < 255) down_votes++;
        up_votes = 0;
        if (down_votes >= down_hold) begin
          tier = want; down_votes = 0; tier_moves++;
        end
      end else begin
        up_votes = 0; down_votes = 0;
      end
    endfunction

    function void note_word(bit [1:0] fn, bit [6:0] load, bit [adtg_pkg::FT_W-1:0] ft);
      tier_word_t w;
      int c;
      bit took;
      words_in++;
      if (fn == adtg_pkg::FUNC_CLEAR) begin
        clear_session();
        expected_words.push_back('{default: 0});
        return;
      end
      c = (load > adtg_pkg::NUM_BUCKETS - 1) ? adtg_pkg::NUM_BUCKETS - 1 : int'(load);
      took = (fn == adtg_pkg::FUNC_OBSERVE) && ft != 0 && ft <= adtg_pkg::FT_MAX &&
             budget != 0;
      if (took) begin
        if (cnt_tab[c] == 0) avg_tab[c] = ft;
        else avg_tab[c] = adtg_pkg::FT_W'((longint'(avg_tab[c]) * adtg_pkg::ALPHA_INV
                          + longint'(ft) * adtg_pkg::ALPHA + 2048) >> 12);
        if (cnt_tab[c] != adtg_pkg::CNT_MAX) cnt_tab[c]++;
      end
      w = judge(c);
      if (took) cast_vote(w.want);
      w.acc = took;
      w.act = tier;
      expected_words.push_back(w);
    endfunction

    function void flag(string what, longint e, longint a);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, e, a);
    endfunction

    function void check_word(tier_word_t got);
      tier_word_t e;
      words_out++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got learned %0d",
                 $time, got.learned);
        return;
      end
      e = expected_words.pop_front();
      if (e.acc != got.acc) flag("accepted", e.acc, got.acc);
      if (e.hist != got.hist) flag("history_found", e.hist, got.hist);
      if (e.learned != got.learned) flag("learned_frame_time", e.learned, got.learned);
      if (e.smp != got.smp) flag("neighbour_samples", e.smp, got.smp);
      if (e.want != got.want) flag("wanted_tier", e.want, got.want);
      if (e.act != got.act) flag("active_tier", e.act, got.act);
    endfunction
  endclass

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           in_valid = 0;
  logic                           in_stall;
  logic [1:0]                     in_func = 0;
  logic [6:0]                     in_load_percent = 0;
  logic [adtg_pkg::FT_W-1:0]      in_frame_time = 0;
  logic                           out_valid;
  logic                           out_stall = 0;
  logic                           out_accepted, out_history_found;
  logic [adtg_pkg::FT_W-1:0]      out_learned_frame_time;
  logic [adtg_pkg::SMP_W-1:0]     out_neighbour_samples;
  logic [1:0]                     out_wanted_tier, out_active_tier;
  logic                           cfg_valid = 0;
  logic                           cfg_ready;
  logic [adtg_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [adtg_pkg::FT_W-1:0]      cfg_data = 0;

  adaptive_detail_tier_governor uut (.*);

  governor_tracker gov = new();

  always #5 clk = ~clk;

  // hard stop against a hung run
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("adaptive_detail_tier_governor verification failed");
      $finish;
    end
  end

  // monitor: everything sampled at the edge, before this edge's updates
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) gov.write_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall)
      gov.note_word(in_func, in_load_percent, in_frame_time);
    if (rst_n && out_valid && !out_stall)
      gov.check_word('{out_accepted, out_history_found, out_learned_frame_time,
                       out_neighbour_samples, out_wanted_tier, out_active_tier});
  end

  // receiver: stall pattern switches whenever the mode age counter wraps; one long hold-off
  bit          long_hold_req = 0;
  bit          long_hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_age = 0;
  always @(posedge clk) begin
    if (mode_age == 150) begin
      mode_age <= 0;
      stall_mode <= $urandom_range(0, 3);
    end else begin
      mode_age <= mode_age + 1;
    end
    if (hold_left != 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      // long hold-off: output register fills, input must back up
      long_hold_done <= 1;
      hold_left <= 600;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= mode_age[2];
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // sender state
  bit          valid_up = 0;
  int unsigned burst_left = 0;
  int          hot_load = 50;
  int unsigned hot_level = 300;
  int unsigned hot_age = 0;

  // offer one word; returns on the edge that takes it
  task automatic send_word(bit [1:0] fn, bit [6:0] load, bit [adtg_pkg::FT_W-1:0] ft);
    in_valid <= 1;
    in_func <= fn;
    in_load_percent <= load;
    in_frame_time <= ft;
    valid_up = 1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
    burst_left = $urandom_range(1, 30);
    if (gap != 0) begin
      in_valid <= 0;
      valid_up = 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all pending words, then let the block go quiet
  task automatic settle();
    if (valid_up) begin
      in_valid <= 0;
      valid_up = 0;
    end
    while (gov.expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned b, int unsigned rr, int unsigned ur,
                            int unsigned uh, int unsigned dh, int unsigned ms);
    int unsigned vals[6];
    vals = '{b, rr, ur, uh, dh, ms};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1;
      cfg_index <= adtg_pkg::CFG_IDX_W'(i);
      cfg_data <= adtg_pkg::FT_W'(vals[i]);
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
    end
    cfg_valid <= 0;
  endtask

  // frame time around the hot level, as a Q8 multiple of the budget
  function automatic bit [adtg_pkg::FT_W-1:0] hot_frame();
    longint unsigned ft;
    ft = (longint'(gov.budget) * (hot_level + $urandom_range(0, 16))) >> 8;
    if (ft == 0) ft = 1;
    if (ft > adtg_pkg::FT_MAX) ft = adtg_pkg::FT_MAX;
    return adtg_pkg::FT_W'(ft);
  endfunction

  task automatic run_traffic(int unsigned n);
    int unsigned pick;
    int ld;
    for (int unsigned i = 0; i < n; i++) begin
      if (hot_age == 0) begin
        hot_age = $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0) hot_load = $urandom_range(0, 100);
        hot_level = $urandom_range(180, 470);
      end
      hot_age--;
      pick = $urandom_range(0, 99);
      ld = hot_load + $urandom_range(0, 4) - 2;
      if (ld < 0) ld = 0;
      if (ld > 127) ld = 127;
      if (pick < 68) send_word(adtg_pkg::FUNC_OBSERVE, 7'(ld), hot_frame());
      else if (pick < 78)
        send_word(adtg_pkg::FUNC_QUERY, 7'($urandom_range(0, 127)),
                  adtg_pkg::FT_W'($urandom));
      else if (pick < 80)
        send_word(adtg_pkg::FUNC_CLEAR, 7'($urandom_range(0, 127)),
                  adtg_pkg::FT_W'($urandom));
      else if (pick < 90)
        send_word(adtg_pkg::FUNC_OBSERVE, 7'($urandom_range(0, 127)),
                  adtg_pkg::FT_W'($urandom));
      else if (pick < 95)
        send_word(adtg_pkg::FUNC_OBSERVE, 7'(ld), pick[0] ? adtg_pkg::FT_W'(0) :
                  adtg_pkg::FT_W'($urandom_range(adtg_pkg::FT_MAX + 1, 262143)));
      else
        send_word(adtg_pkg::FUNC_SPARE, 7'($urandom_range(0, 127)),
                  adtg_pkg::FT_W'($urandom));
      pace();
    end
  endtask

  initial begin
    gov.load_defaults();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, field extremes, clamping, rejects, clear
    send_word(adtg_pkg::FUNC_QUERY, 0, 0);
    send_word(adtg_pkg::FUNC_OBSERVE, 0, 0);
    send_word(adtg_pkg::FUNC_OBSERVE, 0, adtg_pkg::FT_W'(adtg_pkg::FT_MAX + 1));
    send_word(adtg_pkg::FUNC_OBSERVE, 0, 262143);
    send_word(adtg_pkg::FUNC_OBSERVE, 0, adtg_pkg::FT_W'(adtg_pkg::FT_MAX));
    send_word(adtg_pkg::FUNC_OBSERVE, 1, 1);
    send_word(adtg_pkg::FUNC_OBSERVE, 2, 4267);
    send_word(adtg_pkg::FUNC_OBSERVE, 127, 1);
    send_word(adtg_pkg::FUNC_OBSERVE, 100, 7000);
    send_word(adtg_pkg::FUNC_OBSERVE, 98, 5000);
    send_word(adtg_pkg::FUNC_QUERY, 101, 0);
    send_word(adtg_pkg::FUNC_QUERY, 3, 0);
    send_word(adtg_pkg::FUNC_SPARE, 99, 262143);
    for (int i = 0; i < 8; i++) send_word(adtg_pkg::FUNC_OBSERVE, 50, 9000);
    send_word(adtg_pkg::FUNC_QUERY, 50, 0);
    send_word(adtg_pkg::FUNC_CLEAR, 50, 9000);
    send_word(adtg_pkg::FUNC_QUERY, 50, 0);
    settle();

    // default registers, long receiver hold-off part way in
    run_traffic(100);
    long_hold_req = 1;
    run_traffic(150);
    settle();

    // low extremes: every vote moves the tier at once
    write_regs(1, 256, 256, 1, 1, 0);
    send_word(adtg_pkg::FUNC_CLEAR, 0, 0);
    run_traffic(160);
    settle();

    // high extremes
    write_regs(262143, 1023, 1023, 255, 255, 240);
    send_word(adtg_pkg::FUNC_CLEAR, 0, 0);
    run_traffic(160);
    settle();

    // zero budget: nothing learned, nothing decided
    write_regs(0, 300, 400, 3, 3, 5);
    run_traffic(40);
    settle();

    // zero holds
    write_regs(4267, 287, 371, 0, 0, 0);
    send_word(adtg_pkg::FUNC_CLEAR, 0, 0);
    run_traffic(160);
    settle();

    for (int p = 0; p < 5; p++) begin
      int unsigned rr;
      rr = $urandom_range(256, 600);
      write_regs($urandom_range(800, 60000), rr, $urandom_range(rr, 1023),
                 $urandom_range(1, 30), $urandom_range(1, 40), $urandom_range(0, 240));
      send_word(adtg_pkg::FUNC_CLEAR, 0, 0);
      run_traffic(170);
      settle();
    end

    $display("Run covered %0d input words and %0d result words over 10 register settings,",
             gov.words_in, gov.words_out);
    $display("with %0d active tier changes and one long output hold-off.", gov.tier_moves);
    if (gov.errors == 0 && gov.expected_words.size() == 0) begin
      $display("adaptive_detail_tier_governor verification clean");
    end else begin
      $display("%0d mismatches, %0d words never returned", gov.errors,
               gov.expected_words.size());
      $display("adaptive_detail_tier_governor verification failed");
    end
    $finish;
  end

endmodule
